>>> rtl/core/rgb_ycbcr_color_convert_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the colour converter
// ----------------------------------------------------------------------------
`ifndef RGB_YCBCR_COLOR_CONVERT_UNIT_MACROS_SVH
`define RGB_YCBCR_COLOR_CONVERT_UNIT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define RYCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define RYCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rycc_pkg.sv
// ----------------------------------------------------------------------------
// rycc_pkg
// Shared types and constants of the RGB / YCbCr colour converter.
// ----------------------------------------------------------------------------
package rycc_pkg;

    localparam int COMP_W  = 8;
    localparam int TDATA_W = 3 * COMP_W;

    // Conversion direction held in the configuration register
    typedef enum logic {
        DIR_FWD = 1'b0,   // RGB to YCbCr
        DIR_INV = 1'b1    // YCbCr to RGB
    } dir_t;

    // Chroma offset of full-range JFIF
    localparam longint CHROMA_OFFSET = 128;

    // Decimal coefficients as numerator / denominator pairs
    localparam longint KYR_NUM  = 299;     localparam longint KYR_DEN  = 1000;
    localparam longint KYG_NUM  = 587;     localparam longint KYG_DEN  = 1000;
    localparam longint KYB_NUM  = 114;     localparam longint KYB_DEN  = 1000;
    localparam longint KCBR_NUM = 168736;  localparam longint KCBR_DEN = 1000000;
    localparam longint KCBG_NUM = 331264;  localparam longint KCBG_DEN = 1000000;
    localparam longint KCRG_NUM = 418688;  localparam longint KCRG_DEN = 1000000;
    localparam longint KCRB_NUM = 81312;   localparam longint KCRB_DEN = 1000000;
    localparam longint KRCR_NUM = 1402;    localparam longint KRCR_DEN = 1000;
    localparam longint KGCB_NUM = 34414;   localparam longint KGCB_DEN = 100000;
    localparam longint KGCR_NUM = 71414;   localparam longint KGCR_DEN = 100000;
    localparam longint KBCB_NUM = 1772;    localparam longint KBCB_DEN = 1000;

endpackage

>>> rtl/core/rgb_ycbcr_color_convert_unit.sv
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_convert_unit
// Full-range JFIF colour converter, RGB <-> YCbCr, one pixel of three 8-bit components a beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata = {c, b, a}, s_tlast = last pixel
//  m_      | out | m_tvalid/m_tready  | m_tdata = {c, b, a}, m_tlast = last pixel
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data = direction (0 fwd, 1 inv)
//
//  One pixel accepted per clock while the output is not stalled; the result passes
//  four stages (input register, multiply, sum, saturate/output register).
//  The rate is one beat a cycle, set by the nine multipliers of the product
//  stage, each used once per pixel.
//  aresetn clears the stage valid bits and sets direction to forward.
//  A low m_tready holds the stages that are full; empty stages still fill.
// ----------------------------------------------------------------------------
module rgb_ycbcr_color_convert_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    // input pixels
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rycc_pkg::TDATA_W-1:0] s_tdata,   // comp_a[7:0], comp_b[15:8], comp_c[23:16]
    input  logic                         s_tlast,
    // result pixels
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rycc_pkg::TDATA_W-1:0] m_tdata,   // res_a[7:0], res_b[15:8], res_c[23:16]
    output logic                         m_tlast
);

    localparam int CW = FRAC_BITS + 2;            // signed coefficient, |k| < 2
    localparam int OW = rycc_pkg::COMP_W + 1;     // signed operand
    localparam int PW = CW + OW;                  // product
    localparam int SW = PW + 2;                   // sum of three plus offset
    localparam int CMW = rycc_pkg::COMP_W;

    localparam logic signed [CW-1:0] K_Y_R = CW'(((rycc_pkg::KYR_NUM << FRAC_BITS)
        + rycc_pkg::KYR_DEN / 2) / rycc_pkg::KYR_DEN);
    localparam logic signed [CW-1:0] K_Y_G = CW'(((rycc_pkg::KYG_NUM << FRAC_BITS)
        + rycc_pkg::KYG_DEN / 2) / rycc_pkg::KYG_DEN);
    localparam logic signed [CW-1:0] K_Y_B = CW'(((rycc_pkg::KYB_NUM << FRAC_BITS)
        + rycc_pkg::KYB_DEN / 2) / rycc_pkg::KYB_DEN);
    localparam logic signed [CW-1:0] K_CB_R = CW'(((rycc_pkg::KCBR_NUM << FRAC_BITS)
        + rycc_pkg::KCBR_DEN / 2) / rycc_pkg::KCBR_DEN);
    localparam logic signed [CW-1:0] K_CB_G = CW'(((rycc_pkg::KCBG_NUM << FRAC_BITS)
        + rycc_pkg::KCBG_DEN / 2) / rycc_pkg::KCBG_DEN);
    localparam logic signed [CW-1:0] K_CR_G = CW'(((rycc_pkg::KCRG_NUM << FRAC_BITS)
        + rycc_pkg::KCRG_DEN / 2) / rycc_pkg::KCRG_DEN);
    localparam logic signed [CW-1:0] K_CR_B = CW'(((rycc_pkg::KCRB_NUM << FRAC_BITS)
        + rycc_pkg::KCRB_DEN / 2) / rycc_pkg::KCRB_DEN);
    localparam logic signed [CW-1:0] K_R_CR = CW'(((rycc_pkg::KRCR_NUM << FRAC_BITS)
        + rycc_pkg::KRCR_DEN / 2) / rycc_pkg::KRCR_DEN);
    localparam logic signed [CW-1:0] K_G_CB = CW'(((rycc_pkg::KGCB_NUM << FRAC_BITS)
        + rycc_pkg::KGCB_DEN / 2) / rycc_pkg::KGCB_DEN);
    localparam logic signed [CW-1:0] K_G_CR = CW'(((rycc_pkg::KGCR_NUM << FRAC_BITS)
        + rycc_pkg::KGCR_DEN / 2) / rycc_pkg::KGCR_DEN);
    localparam logic signed [CW-1:0] K_B_CB = CW'(((rycc_pkg::KBCB_NUM << FRAC_BITS)
        + rycc_pkg::KBCB_DEN / 2) / rycc_pkg::KBCB_DEN);
    localparam logic signed [CW-1:0] K_ONE  = CW'(longint'(1) << FRAC_BITS);
    localparam logic signed [CW-1:0] K_HALF = CW'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [CW-1:0] K_ZERO = '0;

    localparam logic signed [OW-1:0] OFFSET_OP = OW'(rycc_pkg::CHROMA_OFFSET);
    localparam logic signed [SW-1:0] OFFSET_FX = SW'(rycc_pkg::CHROMA_OFFSET << FRAC_BITS);

    // ---------------- direction register ----------------
    rycc_pkg::dir_t dir_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= rycc_pkg::DIR_FWD;
        end else if (cfg_valid) begin
            dir_reg <= rycc_pkg::dir_t'(cfg_data);
        end
    end

    // ---------------- stage enables ----------------
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic en1, en2, en3, en4;

    assign en4 = !m_valid_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= s_tvalid;
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) m_valid_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic [CMW-1:0]  comp1_reg [3];
    logic            last1_reg;
    rycc_pkg::dir_t  dir1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            comp1_reg[0] <= s_tdata[CMW-1:0];
            comp1_reg[1] <= s_tdata[2*CMW-1:CMW];
            comp1_reg[2] <= s_tdata[3*CMW-1:2*CMW];
            last1_reg    <= s_tlast;
            dir1_reg     <= dir_reg;
        end
    end

    // ---------------- stage 2: coefficient select and multiply ----------------
    logic signed [OW-1:0] op [3];
    logic signed [CW-1:0] coef [3][3];

    always_comb begin
        op[0] = $signed({1'b0, comp1_reg[0]});
        unique case (dir1_reg)
            rycc_pkg::DIR_FWD: begin
                op[1] = $signed({1'b0, comp1_reg[1]});
                op[2] = $signed({1'b0, comp1_reg[2]});
                coef[0][0] = K_Y_R;    coef[0][1] = K_Y_G;    coef[0][2] = K_Y_B;
                coef[1][0] = -K_CB_R;  coef[1][1] = -K_CB_G;  coef[1][2] = K_HALF;
                coef[2][0] = K_HALF;   coef[2][1] = -K_CR_G;  coef[2][2] = -K_CR_B;
            end
            rycc_pkg::DIR_INV: begin
                // chroma centred on zero
                op[1] = $signed({1'b0, comp1_reg[1]}) - OFFSET_OP;
                op[2] = $signed({1'b0, comp1_reg[2]}) - OFFSET_OP;
                coef[0][0] = K_ONE;    coef[0][1] = K_ZERO;   coef[0][2] = K_R_CR;
                coef[1][0] = K_ONE;    coef[1][1] = -K_G_CB;  coef[1][2] = -K_G_CR;
                coef[2][0] = K_ONE;    coef[2][1] = K_B_CB;   coef[2][2] = K_ZERO;
            end
            default: begin
                op[1] = '0;
                op[2] = '0;
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        coef[i][j] = K_ZERO;
                    end
                end
            end
        endcase
    end

    logic signed [PW-1:0] prod2_reg [3][3];
    logic                 last2_reg;
    rycc_pkg::dir_t       dir2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod2_reg[i][j] <= PW'(coef[i][j]) * PW'(op[j]);
                end
            end
            last2_reg <= last1_reg;
            dir2_reg  <= dir1_reg;
        end
    end

    // ---------------- stage 3: sum ----------------
    logic signed [SW-1:0] sum3_reg [3];
    logic                 last3_reg;
    logic signed [SW-1:0] offset [3];

    always_comb begin
        offset[0] = '0;
        offset[1] = (dir2_reg == rycc_pkg::DIR_FWD) ? OFFSET_FX : '0;
        offset[2] = (dir2_reg == rycc_pkg::DIR_FWD) ? OFFSET_FX : '0;
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                sum3_reg[i] <= SW'(prod2_reg[i][0]) + SW'(prod2_reg[i][1])
                             + SW'(prod2_reg[i][2]) + offset[i];
            end
            last3_reg <= last2_reg;
        end
    end

    // ---------------- stage 4: floor, saturate, output register ----------------
    logic [CMW-1:0] sat [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            priority if (sum3_reg[i][SW-1]) begin
                sat[i] = '0;
            end else if (|sum3_reg[i][SW-2:FRAC_BITS+CMW]) begin
                sat[i] = '1;
            end else begin
                sat[i] = sum3_reg[i][FRAC_BITS+CMW-1:FRAC_BITS];
            end
        end
    end

    logic [rycc_pkg::TDATA_W-1:0] m_data_reg;
    logic                         m_last_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            m_data_reg <= {sat[2], sat[1], sat[0]};
            m_last_reg <= last3_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/core/rycc_checker.sv
// ----------------------------------------------------------------------------
// rycc_port_checker
// Port-level checks of the colour converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_ycbcr_color_convert_unit_macros.svh"

module rycc_port_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic                         cfg_data,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [rycc_pkg::TDATA_W-1:0] s_tdata,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [rycc_pkg::TDATA_W-1:0] m_tdata,
    input logic                         m_tlast
);

    // beats in flight; four pipeline stages at most
    logic [2:0] inflight_reg, inflight_next;
    logic       s_beat, m_beat, cfg_beat;

    assign s_beat   = s_tvalid && s_tready;
    assign m_beat   = m_tvalid && m_tready;
    assign cfg_beat = cfg_valid && cfg_ready;

    always_comb begin
        inflight_next = inflight_reg + 3'(s_beat) - 3'(m_beat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `RYCC_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "result beat changed while stalled")
    `RYCC_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_tvalid && s_tready,
        "pipeline not empty after reset")
    `RYCC_ASSERT(a_no_phantom, aclk, aresetn,
        (!m_tvalid || inflight_reg != 3'd0) && inflight_reg <= 3'd4,
        "result beat without matching input beat")
    `RYCC_ASSERT(a_no_block, aclk, aresetn,
        m_tready |-> s_tready,
        "input stalled while output is ready")
    `RYCC_ASSERT(a_known_beats, aclk, aresetn,
        (!s_beat || !$isunknown({s_tdata, s_tlast})) && (!cfg_beat || !$isunknown(cfg_data)),
        "unknown bits on an accepted beat")

endmodule

bind rgb_ycbcr_color_convert_unit rycc_port_checker u_rycc_checker (.*);

>>> verif/rycc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rycc_checker
// Watches the configuration, pixel-in and pixel-out channels of the colour
// converter. Works out the expected pixel for every input beat from its own
// copy of the direction register, then compares each output beat field by
// field against the oldest expected pixel.
// ----------------------------------------------------------------------------
module rycc_checker
    import rycc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               m_tlast,
    output int                 mismatches,
    output int                 outstanding,
    output int                 compared
);

    typedef struct {
        logic [COMP_W-1:0] a;
        logic [COMP_W-1:0] b;
        logic [COMP_W-1:0] c;
        logic              last;
    } pixel_t;

    // unsigned fixed-point coefficient, rounded to nearest
    function automatic longint fx_coef(longint num, longint den);
        return ((num << FRAC_BITS) + den / 2) / den;
    endfunction

    localparam longint FX_UNIT = longint'(1) << FRAC_BITS;
    localparam longint FX_HALF = longint'(1) << (FRAC_BITS - 1);
    localparam longint C_Y_R   = fx_coef(KYR_NUM, KYR_DEN);
    localparam longint C_Y_G   = fx_coef(KYG_NUM, KYG_DEN);
    localparam longint C_Y_B   = fx_coef(KYB_NUM, KYB_DEN);
    localparam longint C_CB_R  = fx_coef(KCBR_NUM, KCBR_DEN);
    localparam longint C_CB_G  = fx_coef(KCBG_NUM, KCBG_DEN);
    localparam longint C_CR_G  = fx_coef(KCRG_NUM, KCRG_DEN);
    localparam longint C_CR_B  = fx_coef(KCRB_NUM, KCRB_DEN);
    localparam longint C_R_CR  = fx_coef(KRCR_NUM, KRCR_DEN);
    localparam longint C_G_CB  = fx_coef(KGCB_NUM, KGCB_DEN);
    localparam longint C_G_CR  = fx_coef(KGCR_NUM, KGCR_DEN);
    localparam longint C_B_CB  = fx_coef(KBCB_NUM, KBCB_DEN);

    dir_t   direction;
    pixel_t expected_pixels[$];
    pixel_t got;
    pixel_t want;
    int     n_bad;

    // drop the fraction, then clamp to a byte
    function automatic logic [COMP_W-1:0] floor_clamp(longint acc);
        longint whole;
        if (acc < 0) return '0;
        whole = acc >>> FRAC_BITS;
        return (whole > 255) ? 8'd255 : whole[COMP_W-1:0];
    endfunction

    function automatic pixel_t convert_pixel(dir_t dir, pixel_t px);
        longint a;
        longint b;
        longint c;
        longint luma;
        longint db;
        longint dr;
        pixel_t res;
        a = longint'(px.a);
        b = longint'(px.b);
        c = longint'(px.c);
        if (dir == DIR_FWD) begin
            res.a = floor_clamp(C_Y_R * a + C_Y_G * b + C_Y_B * c);
            res.b = floor_clamp(CHROMA_OFFSET * FX_UNIT - C_CB_R * a - C_CB_G * b
                                + FX_HALF * c);
            res.c = floor_clamp(CHROMA_OFFSET * FX_UNIT + FX_HALF * a - C_CR_G * b
                                - C_CR_B * c);
        end else begin
            luma  = a * FX_UNIT;
            db    = b - CHROMA_OFFSET;
            dr    = c - CHROMA_OFFSET;
            res.a = floor_clamp(luma + C_R_CR * dr);
            res.b = floor_clamp(luma - C_G_CB * db - C_G_CR * dr);
            res.c = floor_clamp(luma + C_B_CB * db);
        end
        res.last = px.last;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [COMP_W-1:0] exp_v,
                               input logic [COMP_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            n_bad++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            direction = DIR_FWD;
            expected_pixels.delete();
            n_bad = 0;
            mismatches  <= 0;
            outstanding <= 0;
            compared    <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.a    = m_tdata[COMP_W-1:0];
                got.b    = m_tdata[2*COMP_W-1:COMP_W];
                got.c    = m_tdata[3*COMP_W-1:2*COMP_W];
                got.last = m_tlast;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected output beat, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    n_bad++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("res_a", want.a, got.a);
                    check_field("res_b", want.b, got.b);
                    check_field("res_c", want.c, got.c);
                    check_field("last_pixel", {7'd0, want.last}, {7'd0, got.last});
                    compared <= compared + 1;
                end
            end
            if (s_tvalid && s_tready) begin
                got.a    = s_tdata[COMP_W-1:0];
                got.b    = s_tdata[2*COMP_W-1:COMP_W];
                got.c    = s_tdata[3*COMP_W-1:2*COMP_W];
                got.last = s_tlast;
                expected_pixels.push_back(convert_pixel(direction, got));
            end
            // a write at this edge applies to beats from the next edge on
            if (cfg_valid && cfg_ready)
                direction = dir_t'(cfg_data);
            mismatches  <= n_bad;
            outstanding <= expected_pixels.size();
        end
    end

endmodule

>>> verif/tb_rgb_ycbcr_color_convert_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_ycbcr_color_convert_unit
// Drives pixels through the colour converter in both directions: a directed
// set of corner pixels first, then random phases that alternate direction,
// with random gaps and back-pressure (phase 1 is calm). The checker compares.
// ----------------------------------------------------------------------------
module tb_rgb_ycbcr_color_convert_unit;
    import rycc_pkg::*;

    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_BEATS   = 250;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data  = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;   // comp_a[7:0], comp_b[15:8], comp_c[23:16]
    logic               s_tlast   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;          // res_a[7:0], res_b[15:8], res_c[23:16]
    logic               m_tlast;

    int mismatches;
    int outstanding;
    int compared;

    bit calm = 1'b0;   // no gaps and no stalls while set
    int fwd_beats = 0;
    int inv_beats = 0;
    int dir_writes = 0;
    dir_t cur_dir = DIR_FWD;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rgb_ycbcr_color_convert_unit #(
        .FRAC_BITS(16)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rycc_checker #(
        .FRAC_BITS(16)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .outstanding(outstanding),
        .compared   (compared)
    );

    // sink back-pressure
    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 28);

    // biased towards the corners now and then so saturation gets hit often
    function automatic logic [COMP_W-1:0] pick_component();
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(4))
                0:       return 8'd0;
                1:       return 8'd255;
                2:       return 8'd128;
                3:       return 8'd1;
                default: return 8'd254;
            endcase
        end
        return COMP_W'($urandom_range(255));
    endfunction

    task automatic send_pixel(input logic [COMP_W-1:0] a, input logic [COMP_W-1:0] b,
                              input logic [COMP_W-1:0] c, input logic last);
        while (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cur_dir == DIR_FWD) fwd_beats++;
        else inv_beats++;
    endtask

    // hold off the source until the pipeline has drained
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_direction(input dir_t dir);
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_dir = dir;
        dir_writes++;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // forward corners: black, white, primaries, chroma extremes
        write_direction(DIR_FWD);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd170, 8'd85,  8'd170, 1'b1);
        send_pixel(8'd85,  8'd170, 8'd85,  1'b0);

        // inverse corners: negative sums clamp to 0, overshoots clamp to 255
        drain();
        write_direction(DIR_INV);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd0,   8'd128, 8'd128, 1'b0);
        send_pixel(8'd255, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd128, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd128, 8'd255, 8'd0,   1'b1);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd170, 8'd85,  8'd170, 1'b1);
        send_pixel(8'd85,  8'd170, 8'd85,  1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            write_direction(ph % 2 == 0 ? DIR_FWD : DIR_INV);
            calm = (ph == 1);
            repeat (PHASE_BEATS)
                send_pixel(pick_component(), pick_component(), pick_component(),
                           $urandom_range(15) == 0);
        end
        calm = 1'b0;

        drain();
        repeat (10) @(posedge aclk);
        $display("covered %0d forward and %0d inverse pixels, %0d direction writes,",
                 fwd_beats, inv_beats, dir_writes);
        $display("%0d output beats compared, %0d mismatches", compared, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d pixels still expected", outstanding);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
